/* hw/rtl/lcdns_pkg.sv */
`default_nettype none

package lcdns_pkg;

    // request codes
    localparam logic [2:0] FUNC_INIT   = 3'd0;
    localparam logic [2:0] FUNC_CMD    = 3'd1;
    localparam logic [2:0] FUNC_CHAR   = 3'd2;
    localparam logic [2:0] FUNC_POS    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;
    localparam logic [2:0] FUNC_NUMBER = 3'd5;

    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;
    localparam logic [7:0] CLEAR_CMD  = 8'h01;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    localparam int unsigned INIT_LEN = 6;

    // pin-state steps of one byte
    localparam logic [2:0] STEP_HI_SET  = 3'd0;
    localparam logic [2:0] STEP_HI_EN   = 3'd1;
    localparam logic [2:0] STEP_HI_DROP = 3'd2;
    localparam logic [2:0] STEP_LO_SET  = 3'd3;
    localparam logic [2:0] STEP_LO_EN   = 3'd4;
    localparam logic [2:0] STEP_LO_DROP = 3'd5;

    localparam logic [2:0] HOLD_CMD_FIRST  = 3'd0;
    localparam logic [2:0] HOLD_CHAR_FIRST = 3'd4;
    localparam logic [2:0] HOLD_NORMAL     = 3'd2;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] value;
        logic       rs;
        logic       last;
    } t_byte_item;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/char_lcd_nibble_sequencer_core.sv */
`default_nettype none

// channel    dir  handshake           payload
// request    in   i_valid / o_stall   i_func i_byte_value i_row i_col i_number
// pin state  out  o_valid / i_stall   o_rs o_rw o_enable o_data_nibble o_hold_units o_last
//
// Each byte leaves as six pin states, one per cycle when the sink does not stall.
// Init and commands: front pushes one byte per cycle while the FIFO has room; a number first
// runs the divide-by-ten step once per digit (1 to min(5, NUM_DIGITS) digits) before pushing.
// Init sends six bytes; a number sends one byte per digit. The output rate is set by
// the back end's six-step byte sequencer. o_stall is high while the front is busy.
// Synchronous active-low reset clears control; the digit store is written before use.
module char_lcd_nibble_sequencer_core #(
    parameter int unsigned NUM_DIGITS = 5
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_func,
    input  wire  [7:0]  i_byte_value,
    input  wire         i_row,
    input  wire  [5:0]  i_col,
    input  wire  [15:0] i_number,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_rs,
    output logic        o_rw,
    output logic        o_enable,
    output logic [3:0]  o_data_nibble,
    output logic [2:0]  o_hold_units,
    output logic        o_last
);
    import lcdns_pkg::*;

    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_byte_item w_item;
    t_byte_item w_head;

    lcdns_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_number     (i_number),
        .o_push       (w_push),
        .o_item       (w_item),
        .i_full       (w_full)
    );

    lcdns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    lcdns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rs          (o_rs),
        .o_rw          (o_rw),
        .o_enable      (o_enable),
        .o_data_nibble (o_data_nibble),
        .o_hold_units  (o_hold_units),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* hw/rtl/lcdns_front.sv */
`default_nettype none

module lcdns_front #(
    parameter int unsigned NUM_DIGITS = 5
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  [2:0]              i_func,
    input  wire  [7:0]              i_byte_value,
    input  wire                     i_row,
    input  wire  [5:0]              i_col,
    input  wire  [15:0]             i_number,
    output logic                    o_push,
    output lcdns_pkg::t_byte_item   o_item,
    input  wire                     i_full
);
    import lcdns_pkg::*;

    localparam int unsigned IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int unsigned CW = $clog2(NUM_DIGITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ONE  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [7:0]    r_byte,  n_byte;
    logic          r_rs,    n_rs;
    logic [2:0]    r_idx,   n_idx;
    logic [15:0]   r_num,   n_num;
    logic [CW-1:0] r_n,     n_n;
    logic [3:0]    r_digits [NUM_DIGITS];

    logic [31:0]   w_prod;
    logic [15:0]   w_quot;
    logic [15:0]   w_rem;
    logic [CW-1:0] w_prev;
    logic          w_adv;

    assign w_prod = {16'd0, r_num} * DIV10_MUL;
    assign w_quot = {3'd0, w_prod[DIV10_SHIFT+12:DIV10_SHIFT]};
    assign w_rem  = r_num - ((w_quot << 3) + (w_quot << 1));
    assign w_prev = r_n - CW'(1);
    assign w_adv  = o_push && !i_full;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_push = 1'b0;
        o_item = '{value: r_byte, rs: r_rs, last: 1'b1};
        unique case (r_state)
            S_IDLE: ;
            S_ONE:  o_push = 1'b1;
            S_INIT: begin
                o_push = 1'b1;
                o_item = '{value: init_byte(r_idx), rs: 1'b0,
                           last: (r_idx == 3'(INIT_LEN - 1))};
            end
            S_DIV:  ;
            S_DIG: begin
                o_push = 1'b1;
                o_item = '{value: ASCII_ZERO + {4'd0, r_digits[w_prev[IW-1:0]]},
                           rs: 1'b1, last: (r_n == CW'(1))};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_byte  = r_byte;
        n_rs    = r_rs;
        n_idx   = r_idx;
        n_num   = r_num;
        n_n     = r_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx = 3'd0;
                    n_n   = '0;
                    n_num = i_number;
                    n_rs  = 1'b0;
                    unique case (i_func)
                        FUNC_INIT:   n_state = S_INIT;
                        FUNC_CMD: begin
                            n_byte  = i_byte_value;
                            n_state = S_ONE;
                        end
                        FUNC_CHAR: begin
                            n_byte  = i_byte_value;
                            n_rs    = 1'b1;
                            n_state = S_ONE;
                        end
                        FUNC_POS: begin
                            n_byte  = (i_row ? ROW1_BASE : ROW0_BASE) + {2'd0, i_col};
                            n_state = S_ONE;
                        end
                        FUNC_CLEAR: begin
                            n_byte  = CLEAR_CMD;
                            n_state = S_ONE;
                        end
                        FUNC_NUMBER: n_state = S_DIV;
                        default: ;  // unused codes are swallowed
                    endcase
                end
            end
            S_ONE: begin
                if (w_adv) n_state = S_IDLE;
            end
            S_INIT: begin
                if (w_adv) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(INIT_LEN - 1)) n_state = S_IDLE;
                end
            end
            S_DIV: begin
                n_num = w_quot;
                n_n   = r_n + CW'(1);
                if (w_quot == 16'd0 || r_n == CW'(NUM_DIGITS - 1)) n_state = S_DIG;
            end
            S_DIG: begin
                if (w_adv) begin
                    n_n = w_prev;
                    if (r_n == CW'(1)) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 3'd0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
        r_byte <= n_byte;
        r_rs   <= n_rs;
        r_num  <= n_num;
    end

    // digits land least significant first
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) r_digits[r_n[IW-1:0]] <= w_rem[3:0];
    end

endmodule

`default_nettype wire

/* hw/rtl/lcdns_fifo.sv */
`default_nettype none

module lcdns_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  lcdns_pkg::t_byte_item   i_item,
    output logic                    o_full,
    input  wire                     i_pop,
    output logic                    o_empty,
    output lcdns_pkg::t_byte_item   o_head
);
    import lcdns_pkg::*;

    t_byte_item            r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_full    = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + FIFO_PTR_W'(1);
            if (w_do_pop)  r_rd <= r_rd + FIFO_PTR_W'(1);
            if (w_do_push && !w_do_pop)      r_cnt <= r_cnt + FIFO_CNT_W'(1);
            else if (w_do_pop && !w_do_push) r_cnt <= r_cnt - FIFO_CNT_W'(1);
        end
        if (w_do_push) r_mem[r_wr] <= i_item;
    end

endmodule

`default_nettype wire

/* hw/rtl/lcdns_back.sv */
`default_nettype none

module lcdns_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_empty,
    input  lcdns_pkg::t_byte_item   i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic                    o_rs,
    output logic                    o_rw,
    output logic                    o_enable,
    output logic [3:0]              o_data_nibble,
    output logic [2:0]              o_hold_units,
    output logic                    o_last
);
    import lcdns_pkg::*;

    logic [2:0] r_step;
    logic       r_valid;
    logic       r_rs;
    logic       r_en;
    logic [3:0] r_nib;
    logic [2:0] r_hold;
    logic       r_last;
    logic       w_load;
    logic       w_en;
    logic [3:0] w_nib;
    logic [2:0] w_hold;

    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !i_empty && (r_step == STEP_LO_DROP);

    always_comb begin
        w_en   = (r_step == STEP_HI_EN) || (r_step == STEP_LO_EN);
        w_nib  = (r_step < STEP_LO_SET) ? i_head.value[7:4] : i_head.value[3:0];
        w_hold = HOLD_NORMAL;
        if (r_step == STEP_HI_SET) w_hold = i_head.rs ? HOLD_CHAR_FIRST : HOLD_CMD_FIRST;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_HI_SET;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) r_step <= (r_step == STEP_LO_DROP) ? STEP_HI_SET : r_step + 3'd1;
        end
        if (w_load && !i_empty) begin
            r_rs   <= i_head.rs;
            r_en   <= w_en;
            r_nib  <= w_nib;
            r_hold <= w_hold;
            r_last <= i_head.last && (r_step == STEP_LO_DROP);
        end
    end

    assign o_valid       = r_valid;
    assign o_rs          = r_rs;
    assign o_rw          = 1'b0;
    assign o_enable      = r_en;
    assign o_data_nibble = r_nib;
    assign o_hold_units  = r_hold;
    assign o_last        = r_last;

endmodule

`default_nettype wire

/* tb/sv/char_lcd_nibble_sequencer_core_tb.sv */
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core_tb;
    import lcdns_pkg::*;

    localparam int unsigned NUM_DIGITS  = 5;
    localparam int          STOP_IDLE   = 3000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          RAND_ITEMS  = 360;
    localparam int          DIR_ROWS    = 20;

    // codes the block ignores
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    localparam logic [7:0] POWER_UP_SEQ [0:INIT_LEN-1] =
        '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01, 8'h06};

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_BYTE,
        EXP_NONE
    } t_exp_kind;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [3:0] nib;
        logic [2:0] hold;
        logic       fin;
    } t_pin;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  bval;
        logic        row;
        logic [5:0]  col;
        logic [15:0] num;
        t_exp_kind   kind;
        logic [7:0]  xbyte;
        logic        xrs;
    } t_req;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [2:0]  i_func       = '0;
    logic [7:0]  i_byte_value = '0;
    logic        i_row        = 1'b0;
    logic [5:0]  i_col        = '0;
    logic [15:0] i_number     = '0;
    logic        i_stall      = 1'b0;
    wire         o_stall;
    wire         o_valid;
    wire         o_rs;
    wire         o_rw;
    wire         o_enable;
    wire  [3:0]  o_data_nibble;
    wire  [2:0]  o_hold_units;
    wire         o_last;

    // how the item on the request port is to be checked
    t_exp_kind   cur_kind  = EXP_MODEL;
    logic [7:0]  cur_xbyte = '0;
    logic        cur_xrs   = 1'b0;

    t_pin        pin_q[$];
    int          bad_pins   = 0;
    int          idle_run   = 0;
    int          stall_left = 0;
    bit          rx_idle_on = 1'b0;
    bit          tx_idle_on = 1'b0;

    // predictor state
    logic [5:0]  lcd_steps;
    logic [7:0]  lcd_byte;
    logic        lcd_rs;
    logic [2:0]  lcd_init_cnt;
    logic [2:0]  lcd_digit_cnt;
    logic [3:0]  lcd_digits [0:NUM_DIGITS-1];

    t_req        req_tab [0:DIR_ROWS-1];

    char_lcd_nibble_sequencer_core #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rs         (o_rs),
        .o_rw         (o_rw),
        .o_enable     (o_enable),
        .o_data_nibble(o_data_nibble),
        .o_hold_units (o_hold_units),
        .o_last       (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // six pin states per byte: high nibble set/strobe/drop, then low nibble
    function automatic void queue_byte(input logic [7:0] b, input logic rs, input logic fin);
        t_pin p;
        p.rs   = rs;
        p.rw   = 1'b0;
        p.fin  = 1'b0;
        for (int s = 0; s < 6; s++) begin
            p.nib  = (s < 3) ? b[7:4] : b[3:0];
            p.en   = (s == 1 || s == 4);
            p.hold = (s != 0) ? HOLD_NORMAL : (rs ? HOLD_CHAR_FIRST : HOLD_CMD_FIRST);
            if (s == 5)
                p.fin = fin;
            pin_q.push_back(p);
        end
        lcd_byte  = b;
        lcd_rs    = rs;
        lcd_steps = lcd_steps + 6'd6;
    endfunction

    function automatic void predict_pins(input t_req r);
        int          n;
        logic [15:0] v;
        logic [7:0]  pos;
        if (r.func > FUNC_NUMBER)
            return;
        lcd_steps = '0;
        case (r.func)
            FUNC_INIT: begin
                for (int i = 0; i < INIT_LEN; i++) begin
                    queue_byte(POWER_UP_SEQ[i], 1'b0, i == INIT_LEN - 1);
                    lcd_init_cnt = 3'(i + 1);
                end
            end
            FUNC_CMD:   queue_byte(r.bval, 1'b0, 1'b1);
            FUNC_CHAR:  queue_byte(r.bval, 1'b1, 1'b1);
            FUNC_POS: begin
                pos = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.col};
                queue_byte(pos, 1'b0, 1'b1);
            end
            FUNC_CLEAR: queue_byte(CLEAR_CMD, 1'b0, 1'b1);
            default: begin
                n = 0;
                v = r.num;
                do begin
                    lcd_digits[n] = 4'(v % 10);
                    v = v / 10;
                    n++;
                end while (v != 0 && n < NUM_DIGITS);
                lcd_digit_cnt = 3'(n);
                for (int j = n - 1; j >= 0; j--)
                    queue_byte(ASCII_ZERO + {4'h0, lcd_digits[j]}, 1'b1, j == 0);
            end
        endcase
    endfunction

    function automatic void note_mismatch(input t_pin want, input t_pin got, input bit orphan);
        if (bad_pins < 10) begin
            if (orphan)
                $display("unexpected pin state rs=%0d rw=%0d e=%0d d=%h hold=%0d last=%0d",
                         got.rs, got.rw, got.en, got.nib, got.hold, got.fin);
            else
                $display({"pin state mismatch: exp rs=%0d rw=%0d e=%0d d=%h hold=%0d last=%0d",
                          " got rs=%0d rw=%0d e=%0d d=%h hold=%0d last=%0d"},
                         want.rs, want.rw, want.en, want.nib, want.hold, want.fin,
                         got.rs, got.rw, got.en, got.nib, got.hold, got.fin);
        end
        bad_pins++;
    endfunction

    // request side is predicted before the pin side is checked in the same cycle
    always @(posedge i_clk) begin
        t_req r;
        t_pin got;
        t_pin want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                r = '{i_func, i_byte_value, i_row, i_col, i_number, cur_kind, cur_xbyte,
                      cur_xrs};
                case (cur_kind)
                    EXP_BYTE: begin
                        lcd_steps = '0;
                        queue_byte(cur_xbyte, cur_xrs, 1'b1);
                    end
                    EXP_NONE: ;
                    default:  predict_pins(r);
                endcase
            end
            if (o_valid && !i_stall) begin
                got = {o_rs, o_rw, o_enable, o_data_nibble, o_hold_units, o_last};
                if (pin_q.size() == 0) begin
                    note_mismatch(got, got, 1'b1);
                end else begin
                    want = pin_q.pop_front();
                    if (got !== want)
                        note_mismatch(want, got, 1'b0);
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STOP_IDLE) begin
                $display("watchdog: no progress for %0d cycles", STOP_IDLE);
                $display("char_lcd_nibble_sequencer_core regression: fail");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // sink stall pattern
    always @(posedge i_clk) begin
        int g;
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_on) begin
            g = pick_gap();
            if (g > 3)
                g = g + 10;
            stall_left = (g > 0) ? g - 1 : 0;
            i_stall <= (g > 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_req(input t_req r);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= r.func;
        i_byte_value <= r.bval;
        i_row        <= r.row;
        i_col        <= r.col;
        i_number     <= r.num;
        cur_kind     <= r.kind;
        cur_xbyte    <= r.xbyte;
        cur_xrs      <= r.xrs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold off new requests until every predicted pin state is out
    task automatic drain_pins();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pin_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req rand_req();
        t_req r;
        int   p;
        r.bval  = 8'($urandom_range(0, 255));
        r.row   = 1'($urandom_range(0, 1));
        r.col   = 6'($urandom_range(0, 63));
        r.kind  = EXP_MODEL;
        r.xbyte = '0;
        r.xrs   = 1'b0;
        p = $urandom_range(0, 99);
        if (p < 25)
            r.num = 16'($urandom_range(0, 9));
        else if (p < 45)
            case ($urandom_range(0, 9))
                0: r.num = 16'd9;
                1: r.num = 16'd10;
                2: r.num = 16'd99;
                3: r.num = 16'd100;
                4: r.num = 16'd999;
                5: r.num = 16'd1000;
                6: r.num = 16'd9999;
                7: r.num = 16'd10000;
                8: r.num = 16'd65534;
                default: r.num = 16'd65535;
            endcase
        else
            r.num = 16'($urandom_range(0, 65535));
        p = $urandom_range(0, 99);
        if (p < 6)       r.func = p[0] ? FUNC_SPARE7 : FUNC_SPARE6;
        else if (p < 14) r.func = FUNC_INIT;
        else if (p < 29) r.func = FUNC_CMD;
        else if (p < 54) r.func = FUNC_CHAR;
        else if (p < 69) r.func = FUNC_POS;
        else if (p < 76) r.func = FUNC_CLEAR;
        else             r.func = FUNC_NUMBER;
        return r;
    endfunction

    initial begin
        int   sent;
        int   mode;
        t_req r;
        lcd_steps     = '0;
        lcd_byte      = '0;
        lcd_rs        = 1'b0;
        lcd_init_cnt  = '0;
        lcd_digit_cnt = '0;
        req_tab = '{
            '{FUNC_INIT,   8'h00, 1'b0, 6'd0,  16'd0,     EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_CMD,    8'h00, 1'b0, 6'd0,  16'd0,     EXP_BYTE,  8'h00, 1'b0},
            '{FUNC_CMD,    8'hFF, 1'b1, 6'd63, 16'hFFFF,  EXP_BYTE,  8'hFF, 1'b0},
            '{FUNC_CHAR,   8'h00, 1'b0, 6'd0,  16'd0,     EXP_BYTE,  8'h00, 1'b1},
            '{FUNC_CHAR,   8'hFF, 1'b0, 6'd0,  16'd0,     EXP_BYTE,  8'hFF, 1'b1},
            '{FUNC_CHAR,   8'h41, 1'b0, 6'd0,  16'd0,     EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_POS,    8'hFF, 1'b0, 6'd0,  16'd0,     EXP_BYTE,  8'h80, 1'b0},
            '{FUNC_POS,    8'h00, 1'b0, 6'd63, 16'd0,     EXP_BYTE,  8'hBF, 1'b0},
            '{FUNC_POS,    8'h00, 1'b1, 6'd0,  16'd0,     EXP_BYTE,  8'hC0, 1'b0},
            '{FUNC_POS,    8'h00, 1'b1, 6'd63, 16'd0,     EXP_BYTE,  8'hFF, 1'b0},
            '{FUNC_CLEAR,  8'hAA, 1'b1, 6'd21, 16'd0,     EXP_BYTE,  8'h01, 1'b0},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd0,     EXP_BYTE,  8'h30, 1'b1},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd9,     EXP_BYTE,  8'h39, 1'b1},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd10,    EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd65535, EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd10000, EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_NUMBER, 8'h00, 1'b0, 6'd0,  16'd12345, EXP_MODEL, 8'h00, 1'b0},
            '{FUNC_SPARE6, 8'h12, 1'b0, 6'd3,  16'd77,    EXP_NONE,  8'h00, 1'b0},
            '{FUNC_SPARE7, 8'hFF, 1'b1, 6'd63, 16'hFFFF,  EXP_NONE,  8'h00, 1'b0},
            '{FUNC_POS,    8'h00, 1'b1, 6'd5,  16'd0,     EXP_MODEL, 8'h00, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, back to back first, then with gaps on both sides
        for (int k = 0; k < DIR_ROWS; k++)
            send_req(req_tab[k]);
        drain_pins();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        for (int k = 0; k < DIR_ROWS; k++)
            send_req(req_tab[k]);
        drain_pins();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 50 == 0) begin
                mode = $urandom_range(0, 3);
                tx_idle_on = mode[0];
                rx_idle_on <= mode[1];
            end
            if (sent == RAND_ITEMS / 2)
                drain_pins();
            r = rand_req();
            send_req(r);
            if (r.func <= FUNC_NUMBER)
                sent++;
        end

        drain_pins();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pin_q.size() != 0) begin
            $display("%0d expected pin states never arrived", pin_q.size());
            bad_pins++;
        end
        if (bad_pins == 0)
            $display("char_lcd_nibble_sequencer_core regression: pass");
        else
            $display("char_lcd_nibble_sequencer_core regression: fail");
        $finish;
    end

endmodule
